### design/tls_pkg.sv
// ----------------------------------------------------------------------------
// tls_pkg
// Shared types and constants for the transposing linear search block.
// ----------------------------------------------------------------------------
package tls_pkg;

   localparam int LIST_DEPTH_DEFAULT = 32;

   localparam int KEY_W  = 32;
   localparam int SLOT_W = 5;
   localparam int POS_W  = 5;
   localparam int LEN_W  = 6;

   localparam int REQ_TDATA_W = 40;
   localparam int RSP_TDATA_W = 8;

   localparam logic OP_LOAD   = 1'b0;
   localparam logic OP_SEARCH = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_SWAP_HI,
      ST_SWAP_LO,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic load;
      logic start;
      logic step;
      logic hit_take;
      logic miss_take;
      logic swap_hi;
      logic swap_lo;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic hit;
      logic miss_end;
      logic hit_at_zero;
      logic len_zero;
      logic out_free;
   } status_type;

endpackage

### design/tls_ctrl.sv
// ----------------------------------------------------------------------------
// tls_ctrl
// Sequencer for loads, the entry scan, the transposing swap and the response.
// ----------------------------------------------------------------------------
module tls_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic                req_op,
   input  tls_pkg::status_type status,
   output tls_pkg::cmd_type    cmd
);

   tls_pkg::state_type state_ff;
   tls_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tls_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         tls_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               if (req_op == tls_pkg::OP_LOAD) begin
                  cmd.load = 1'b1;
               end else begin
                  cmd.start = 1'b1;
                  if (status.len_zero) begin
                     cmd.miss_take = 1'b1;
                     state_in      = tls_pkg::ST_DONE;
                  end else begin
                     state_in = tls_pkg::ST_SCAN;
                  end
               end
            end
         end
         tls_pkg::ST_SCAN: begin
            if (status.hit) begin
               cmd.hit_take = 1'b1;
               state_in     = status.hit_at_zero ? tls_pkg::ST_DONE : tls_pkg::ST_SWAP_HI;
            end else if (status.miss_end) begin
               cmd.miss_take = 1'b1;
               state_in      = tls_pkg::ST_DONE;
            end else begin
               cmd.step = 1'b1;
            end
         end
         tls_pkg::ST_SWAP_HI: begin
            cmd.swap_hi = 1'b1;
            state_in    = tls_pkg::ST_SWAP_LO;
         end
         tls_pkg::ST_SWAP_LO: begin
            cmd.swap_lo = 1'b1;
            state_in    = tls_pkg::ST_DONE;
         end
         tls_pkg::ST_DONE: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = tls_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = tls_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

### design/tls_datapath.sv
// ----------------------------------------------------------------------------
// tls_datapath
// Entry memory, scan address and compare, swap write-back and response register.
// ----------------------------------------------------------------------------
module tls_datapath #(
   parameter int LIST_DEPTH = tls_pkg::LIST_DEPTH_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_wr_en,
   input  logic [tls_pkg::LEN_W-1:0]  csr_wr_data,
   input  logic [tls_pkg::SLOT_W-1:0] req_slot,
   input  logic [tls_pkg::KEY_W-1:0]  req_key,
   input  logic                       rsp_tready,
   output logic                       rsp_tvalid,
   output logic                       rsp_found,
   output logic [tls_pkg::POS_W-1:0]  rsp_position,
   input  tls_pkg::cmd_type           cmd,
   output tls_pkg::status_type        status
);

   localparam int AW = $clog2(LIST_DEPTH);
   localparam int CW = $clog2(LIST_DEPTH + 1);
   localparam int LW = (CW > tls_pkg::LEN_W) ? CW : tls_pkg::LEN_W;

   logic [tls_pkg::KEY_W-1:0] mem [LIST_DEPTH];

   logic [tls_pkg::LEN_W-1:0] list_length_ff;
   logic [CW-1:0]             len_ff;
   logic [CW-1:0]             addr_ff;
   logic [tls_pkg::KEY_W-1:0] key_ff;
   logic [tls_pkg::KEY_W-1:0] rd_data_ff;
   logic [tls_pkg::KEY_W-1:0] prev_ff;
   logic                      rd_valid_ff;
   logic                      rd_last_ff;
   logic [AW-1:0]             rd_pos_ff;
   logic [AW-1:0]             hit_pos_ff;
   logic                      res_found_ff;
   logic [tls_pkg::POS_W-1:0] res_pos_ff;
   logic                      rsp_valid_ff;
   logic                      rsp_valid_in;
   logic                      rsp_found_ff;
   logic [tls_pkg::POS_W-1:0] rsp_pos_ff;

   logic [LW-1:0]             len_req;
   logic [LW-1:0]             len_sat;
   logic [31:0]               slot_w;
   logic [31:0]               pos_w;
   logic                      hit;
   logic                      wr_en;
   logic [AW-1:0]             wr_addr;
   logic [tls_pkg::KEY_W-1:0] wr_data;

   assign len_req = LW'(list_length_ff);
   assign len_sat = (len_req > LW'(LIST_DEPTH)) ? LW'(LIST_DEPTH) : len_req;
   assign slot_w  = 32'(req_slot);
   assign pos_w   = 32'(rd_pos_ff);
   assign hit     = rd_valid_ff && (rd_data_ff == key_ff);

   assign status.hit         = hit;
   assign status.miss_end    = rd_valid_ff && rd_last_ff && !hit;
   assign status.hit_at_zero = (rd_pos_ff == '0);
   assign status.len_zero    = (list_length_ff == '0);
   assign status.out_free    = !rsp_valid_ff || rsp_tready;

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = slot_w[AW-1:0];
      wr_data = req_key;
      if (cmd.load) begin
         wr_en = (slot_w < 32'(LIST_DEPTH));
      end else if (cmd.swap_hi) begin
         wr_en   = 1'b1;
         wr_addr = hit_pos_ff;
         wr_data = prev_ff;
      end else if (cmd.swap_lo) begin
         wr_en   = 1'b1;
         wr_addr = hit_pos_ff - AW'(1);
         wr_data = key_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (cmd.step) begin
         rd_data_ff <= mem[addr_ff[AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         list_length_ff <= '0;
      end else if (csr_wr_en) begin
         list_length_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff <= 1'b0;
         addr_ff     <= '0;
      end else if (cmd.start) begin
         rd_valid_ff <= 1'b0;
         addr_ff     <= '0;
      end else if (cmd.step) begin
         rd_valid_ff <= (addr_ff < len_ff);
         addr_ff     <= addr_ff + CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         key_ff <= req_key;
         len_ff <= CW'(len_sat);
      end
      if (cmd.step) begin
         rd_pos_ff  <= addr_ff[AW-1:0];
         rd_last_ff <= (addr_ff == len_ff - CW'(1));
         if (rd_valid_ff) begin
            prev_ff <= rd_data_ff;
         end
      end
      if (cmd.hit_take) begin
         hit_pos_ff   <= rd_pos_ff;
         res_found_ff <= 1'b1;
         res_pos_ff   <= pos_w[tls_pkg::POS_W-1:0];
      end else if (cmd.miss_take) begin
         res_found_ff <= 1'b0;
         res_pos_ff   <= '0;
      end
      if (cmd.emit) begin
         rsp_found_ff <= res_found_ff;
         rsp_pos_ff   <= res_pos_ff;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_found    = rsp_found_ff;
   assign rsp_position = rsp_pos_ff;

endmodule

### design/transpose_linear_search.sv
// ----------------------------------------------------------------------------
// transpose_linear_search
// Self-organizing list of signed 32-bit entries, searched with transposition.
// ----------------------------------------------------------------------------
// Usage:
//   Set the list length through csr_wr_en / csr_wr_data while the block is idle.
//   Each req_ item is a load (tuser op = 0) that writes key_value into entry slot
//   and gives no response, or a search (op = 1) that gives one rsp_ item.
//   A search scans entries 0 .. length-1, capped at LIST_DEPTH-1, one per cycle
//   through the entry memory read port; the first match reports found and its
//   position, then the match is swapped with the entry before it (two memory
//   writes, none at position 0). A load is taken in the idle state; a search
//   runs the scan, the swap on a match away from position 0, and then loads the
//   response register.
//   A new item is taken only after the previous one's response is registered;
//   the next item is accepted while that response still waits on rsp_tready.
//   A stalled receiver holds the response and stops the block only once a
//   second response is ready. Reset clears the length to zero and empties the
//   response register; entries are undefined until loaded.
// ----------------------------------------------------------------------------
module transpose_linear_search #(
   parameter int LIST_DEPTH = tls_pkg::LIST_DEPTH_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_wr_en,
   input  logic [tls_pkg::LEN_W-1:0]        csr_wr_data,   // list_length
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [tls_pkg::REQ_TDATA_W-1:0]  req_tdata,     // slot[4:0], key_value[36:5]
   input  logic                             req_tuser,     // op
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [tls_pkg::RSP_TDATA_W-1:0]  rsp_tdata,     // position[4:0]
   output logic                             rsp_tuser      // found
);

   tls_pkg::cmd_type          cmd;
   tls_pkg::status_type       status;
   logic [tls_pkg::POS_W-1:0] rsp_position;

   tls_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_op     (req_tuser),
      .status     (status),
      .cmd        (cmd)
   );

   tls_datapath #(
      .LIST_DEPTH (LIST_DEPTH)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .csr_wr_en    (csr_wr_en),
      .csr_wr_data  (csr_wr_data),
      .req_slot     (req_tdata[tls_pkg::SLOT_W-1:0]),
      .req_key      (req_tdata[tls_pkg::SLOT_W +: tls_pkg::KEY_W]),
      .rsp_tready   (rsp_tready),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_found    (rsp_tuser),
      .rsp_position (rsp_position),
      .cmd          (cmd),
      .status       (status)
   );

   assign rsp_tdata = {(tls_pkg::RSP_TDATA_W - tls_pkg::POS_W)'(0), rsp_position};

endmodule

### design/tls_checker.sv
// ----------------------------------------------------------------------------
// tls_checker
// Port-level checks for the transposing linear search block.
// ----------------------------------------------------------------------------
module tls_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic                            req_tuser,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [tls_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input logic                            rsp_tuser
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response changed while stalled");

   a_miss_pos_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata == '0)
      else $error("miss response carries a nonzero position");

   a_load_silent: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser == tls_pkg::OP_LOAD) && !rsp_tvalid
      |=> !rsp_tvalid)
      else $error("load item produced a response");

   a_search_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser == tls_pkg::OP_SEARCH) |=> !req_tready)
      else $error("item accepted while a search is in progress");

endmodule

bind transpose_linear_search tls_checker u_tls_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

### tb/tb_transpose_linear_search.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_transpose_linear_search
// Drives load and search items into the transposing list search block, keeps
// a shadow copy of the list that is reordered the same way on every hit, and
// checks found and position of every response in order. Covers zero, full
// and saturated lengths, extreme keys, hits at the head, duplicates and long
// random phases with and without idle cycles on both streams.
// ----------------------------------------------------------------------------
module tb_transpose_linear_search;

   localparam int LIST_DEPTH  = tls_pkg::LIST_DEPTH_DEFAULT;
   localparam int KEY_W       = tls_pkg::KEY_W;
   localparam int SLOT_W      = tls_pkg::SLOT_W;
   localparam int POS_W       = tls_pkg::POS_W;
   localparam int LEN_W       = tls_pkg::LEN_W;
   localparam int REQ_TDATA_W = tls_pkg::REQ_TDATA_W;
   localparam int RSP_TDATA_W = tls_pkg::RSP_TDATA_W;
   localparam int CYCLE_LIMIT = 400000;
   localparam int SETTLE_WAIT = LIST_DEPTH + 8;

   typedef struct {
      logic             found;
      logic [POS_W-1:0] position;
   } search_result_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   csr_wr_en;
   logic [LEN_W-1:0]       csr_wr_data;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata;   // slot[4:0], key_value[36:5]
   logic                   req_tuser;   // op
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_TDATA_W-1:0] rsp_tdata;   // position[4:0]
   logic                   rsp_tuser;   // found

   logic signed [KEY_W-1:0] list_store [LIST_DEPTH];
   int                      list_len;
   search_result_type       search_results_q [$];
   int                      fail_count  = 0;
   int                      cycle_count = 0;
   bit                      calm        = 1'b0;

   transpose_linear_search #(.LIST_DEPTH(LIST_DEPTH)) u_top (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   task automatic update_list(input logic op, input logic [SLOT_W-1:0] slot,
                              input logic signed [KEY_W-1:0] key);
      int                      span;
      search_result_type       res;
      logic signed [KEY_W-1:0] held;
      if (op == tls_pkg::OP_LOAD) begin
         list_store[slot] = key;
      end else begin
         span = (list_len > LIST_DEPTH) ? LIST_DEPTH : list_len;
         res.found    = 1'b0;
         res.position = '0;
         for (int i = 0; i < span; i++) begin
            if (!res.found && list_store[i] == key) begin
               res.found    = 1'b1;
               res.position = POS_W'(i);
               if (i > 0) begin
                  held              = list_store[i];
                  list_store[i]     = list_store[i - 1];
                  list_store[i - 1] = held;
               end
            end
         end
         search_results_q.push_back(res);
      end
   endtask

   task automatic send_item(input logic op, input logic [SLOT_W-1:0] slot,
                            input logic signed [KEY_W-1:0] key);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 6);
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {3'b000, key, slot};
      do @(posedge clock); while (!req_tready);
      update_list(op, slot, key);
   endtask

   task automatic settle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (search_results_q.size() != 0) @(posedge clock);
      repeat (SETTLE_WAIT) @(posedge clock);
   endtask

   task automatic set_length(input int len);
      settle();
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= LEN_W'(len);
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      list_len = len;
   endtask

   // receiver: stall a random number of cycles before each item
   initial begin
      int stall;
      wait (!reset);
      forever begin
         @(negedge clock);
         stall = calm ? 0 : $urandom_range(0, 6);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   always @(posedge clock) begin
      search_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (search_results_q.size() == 0) begin
            $display("%0t: unexpected item found=%0b position=%0d",
                     $time, rsp_tuser, rsp_tdata[POS_W-1:0]);
            fail_count++;
         end else begin
            want = search_results_q.pop_front();
            if (rsp_tuser !== want.found) begin
               $display("%0t: found expected %0b actual %0b",
                        $time, want.found, rsp_tuser);
               fail_count++;
            end
            if (rsp_tdata[POS_W-1:0] !== want.position) begin
               $display("%0t: position expected %0d actual %0d",
                        $time, want.position, rsp_tdata[POS_W-1:0]);
               fail_count++;
            end
         end
      end
   end

   task automatic test_basics();
      send_item(tls_pkg::OP_SEARCH, 5'd9, 32'sd5);
      set_length(4);
      send_item(tls_pkg::OP_LOAD, 5'd0, 32'sh8000_0000);
      send_item(tls_pkg::OP_LOAD, 5'd1, 32'sh7FFF_FFFF);
      send_item(tls_pkg::OP_LOAD, 5'd2, 32'sd0);
      send_item(tls_pkg::OP_LOAD, 5'd3, -32'sd1);
      send_item(tls_pkg::OP_LOAD, 5'd31, 32'sd12345);
      send_item(tls_pkg::OP_SEARCH, 5'd0, -32'sd1);
      send_item(tls_pkg::OP_SEARCH, 5'd31, -32'sd1);
      send_item(tls_pkg::OP_SEARCH, 5'd0, 32'sh8000_0000);
      send_item(tls_pkg::OP_SEARCH, 5'd0, 32'sd12345);
      send_item(tls_pkg::OP_SEARCH, 5'd0, 32'sd0);
      send_item(tls_pkg::OP_LOAD, 5'd3, 32'sd0);
      send_item(tls_pkg::OP_SEARCH, 5'd0, 32'sd0);
      send_item(tls_pkg::OP_SEARCH, 5'd0, 32'sd0);
      send_item(tls_pkg::OP_SEARCH, 5'd0, 32'sh7FFF_FFFF);
   endtask

   task automatic test_full_length();
      for (int s = 0; s < LIST_DEPTH; s++)
         send_item(tls_pkg::OP_LOAD, SLOT_W'(s), $urandom);
      set_length(LIST_DEPTH);
      send_item(tls_pkg::OP_SEARCH, 5'd0, list_store[LIST_DEPTH - 1]);
      send_item(tls_pkg::OP_SEARCH, 5'd0, list_store[0]);
      send_item(tls_pkg::OP_SEARCH, 5'd0, 32'sd12345);
      set_length(63);
      send_item(tls_pkg::OP_SEARCH, 5'd0, list_store[LIST_DEPTH - 1]);
      send_item(tls_pkg::OP_SEARCH, 5'd0, 32'sd12345);
      set_length(33);
      send_item(tls_pkg::OP_SEARCH, 5'd0, list_store[LIST_DEPTH - 2]);
   endtask

   task automatic random_phase(input int len, input int count, input bit quiet);
      int                      eff;
      int                      pick;
      logic signed [KEY_W-1:0] pool [3];
      pool[0] = 32'sd0;
      pool[1] = -32'sd1;
      pool[2] = 32'sd5;
      set_length(len);
      calm = quiet;
      eff = (len > LIST_DEPTH) ? LIST_DEPTH : len;
      for (int n = 1; n <= count; n++) begin
         pick = $urandom_range(0, 99);
         if (pick < 55 && eff > 0)
            send_item(tls_pkg::OP_SEARCH, SLOT_W'($urandom),
                      list_store[$urandom_range(0, eff - 1)]);
         else if (pick < 70)
            send_item(tls_pkg::OP_SEARCH, SLOT_W'($urandom), $urandom);
         else if (pick < 82)
            send_item(tls_pkg::OP_LOAD, SLOT_W'($urandom), $urandom);
         else if (pick < 90)
            send_item(tls_pkg::OP_LOAD, SLOT_W'($urandom),
                      pool[$urandom_range(0, 2)]);
         else
            send_item(tls_pkg::OP_SEARCH, SLOT_W'($urandom),
                      pool[$urandom_range(0, 2)]);
         if (n % 60 == 0)
            settle();
      end
      calm = 1'b0;
   endtask

   task automatic test_random();
      random_phase(LIST_DEPTH, 80, 1'b0);
      random_phase(63, 70, 1'b1);
      random_phase(1, 50, 1'b0);
      random_phase(7, 70, 1'b0);
      random_phase($urandom_range(2, 31), 70, 1'b1);
      random_phase(0, 20, 1'b0);
      random_phase(33, 50, 1'b0);
   endtask

   initial begin
      csr_wr_en   = 1'b0;
      csr_wr_data = '0;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = tls_pkg::OP_LOAD;
      rsp_tready  = 1'b0;
      list_len    = 0;
      foreach (list_store[i]) list_store[i] = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_basics();
      test_full_length();
      test_random();
      settle();
      if (fail_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

### filelist.f
design/tls_pkg.sv
design/tls_ctrl.sv
design/tls_datapath.sv
design/transpose_linear_search.sv
design/tls_checker.sv
tb/tb_transpose_linear_search.sv
